>>> hw/rtl/combination_cover_search_counter_macros.svh
// ----------------------------------------------------------------------------
// combination_cover_search_counter assertion macros
// Concurrent assertion helpers, compiled away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef COMBINATION_COVER_SEARCH_COUNTER_MACROS_SVH
`define COMBINATION_COVER_SEARCH_COUNTER_MACROS_SVH

`ifndef SYNTH

`define CCSC_ASSERT_IMPLY(label, clk_s, rst_n_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("assertion failed");

`define CCSC_ASSERT_NEXT(label, clk_s, rst_n_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define CCSC_ASSERT_IMPLY(label, clk_s, rst_n_s, ante, cons)

`define CCSC_ASSERT_NEXT(label, clk_s, rst_n_s, ante, cons)

`endif

`endif

>>> hw/rtl/ccsc_pkg.sv
// ----------------------------------------------------------------------------
// ccsc_pkg
// Shared widths, register indexes and interface types of the cover search
// counter.
// ----------------------------------------------------------------------------
package ccsc_pkg;

	localparam int MASK_W      = 64;
	localparam int POS_W       = $clog2(MASK_W);
	localparam int TRIES_W     = 61;
	localparam int CNT_W       = 7;
	localparam int PROD_W      = TRIES_W + CNT_W;
	localparam int MAX_LEN_DEF = 64;

	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_DATA_COUNT  = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_CHECK_COUNT = 1'd1;

	localparam logic [CNT_W-1:0] DATA_COUNT_RST  = 7'd26;
	localparam logic [CNT_W-1:0] CHECK_COUNT_RST = 7'd5;

	typedef struct packed {
		logic               start;
		logic [TRIES_W-1:0] value;
		logic [CNT_W-1:0]   mult;
		logic [CNT_W-1:0]   divisor;
	} md_req_t;

	typedef struct packed {
		logic               done;
		logic [TRIES_W-1:0] quot;
	} md_rsp_t;

endpackage

>>> hw/rtl/combination_cover_search_counter.sv
// ----------------------------------------------------------------------------
// combination_cover_search_counter
// Ranks the first covering pattern of an erasure mask among all n-bit
// patterns with check_count ones, in decreasing lexicographic order.
// ----------------------------------------------------------------------------
// A mask is taken when start is high and busy is low; busy stays high until
// the result is shown on tries, found and config_error for the single cycle
// in which done is high, and the receiver must take it then. A bad length
// holds busy for that one result cycle only. Otherwise busy covers counting the
// erasures, a setup state, building the pattern, walking it from the end and
// the result cycle. Every walk step after the first one has been passed,
// except at the last position, waits in the bit-serial divide of ccsc_muldiv
// that updates the running binomial. Configuration writes are always
// accepted and must only be made while busy is low.
`include "combination_cover_search_counter_macros.svh"

module combination_cover_search_counter import ccsc_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [MASK_W-1:0]    erasure_mask,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data,
	output logic                 done,
	output logic [TRIES_W-1:0]   tries,
	output logic                 found,
	output logic                 config_error
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_COUNT = 3'd1;
	localparam logic [2:0] ST_PREP  = 3'd2;
	localparam logic [2:0] ST_FILL  = 3'd3;
	localparam logic [2:0] ST_WALK  = 3'd4;
	localparam logic [2:0] ST_WAIT  = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   dc_q;
	logic [CNT_W-1:0]   cc_q;
	logic [MASK_W-1:0]  mask_q;
	logic [MASK_W-1:0]  pat_q;
	logic [CNT_W-1:0]   n_q;
	logic [POS_W-1:0]   idx_q;
	logic [CNT_W-1:0]   ones_q;
	logic [CNT_W-1:0]   need_q;
	logic [CNT_W-1:0]   s_q;
	logic [TRIES_W-1:0] v_q;
	logic [TRIES_W-1:0] acc_q;
	logic               found_q;
	logic               err_q;

	logic [CNT_W:0]     n_sum;
	logic               mask_bit;
	logic               last_pos;
	logic               fill_bit;
	logic               walk_bit;
	md_req_t            md_req;
	md_rsp_t            md_rsp;

	assign n_sum    = {1'b0, dc_q} + {1'b0, cc_q};
	assign mask_bit = mask_q[~idx_q];
	assign last_pos = (idx_q == POS_W'(n_q - CNT_W'(1)));
	assign walk_bit = pat_q[0];

	always_comb begin
		if (found_q) begin
			fill_bit = mask_bit | (need_q != '0);
		end else begin
			fill_bit = ({1'b0, idx_q} >= dc_q);
		end
	end

	always_comb begin
		md_req.value   = v_q;
		md_req.mult    = {1'b0, idx_q} + CNT_W'(1);
		md_req.divisor = walk_bit ? s_q : ({1'b0, idx_q} + CNT_W'(2) - s_q);
		md_req.start   = (state_q == ST_WALK) && !last_pos && (s_q != '0);
	end

	ccsc_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_q <= DATA_COUNT_RST;
			cc_q <= CHECK_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DATA_COUNT:  dc_q <= cfg_data;
				REG_CHECK_COUNT: cc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mask_q  <= '0;
			pat_q   <= '0;
			n_q     <= '0;
			idx_q   <= '0;
			ones_q  <= '0;
			need_q  <= '0;
			s_q     <= '0;
			v_q     <= '0;
			acc_q   <= '0;
			found_q <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (n_sum == '0 || n_sum > (CNT_W+1)'(MAX_LEN)) begin
							acc_q   <= '0;
							found_q <= 1'b0;
							err_q   <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							mask_q  <= erasure_mask;
							n_q     <= CNT_W'(n_sum);
							idx_q   <= '0;
							ones_q  <= '0;
							err_q   <= 1'b0;
							state_q <= ST_COUNT;
						end
					end
				end
				ST_COUNT: begin
					ones_q <= ones_q + CNT_W'(mask_bit);
					if (last_pos) begin
						idx_q   <= '0;
						state_q <= ST_PREP;
					end else begin
						idx_q <= idx_q + POS_W'(1);
					end
				end
				ST_PREP: begin
					found_q <= (ones_q <= cc_q);
					need_q  <= cc_q - ones_q;
					state_q <= ST_FILL;
				end
				ST_FILL: begin
					pat_q <= {pat_q[MASK_W-2:0], fill_bit};
					if (found_q && !mask_bit && need_q != '0) begin
						need_q <= need_q - CNT_W'(1);
					end
					if (last_pos) begin
						idx_q   <= '0;
						s_q     <= '0;
						v_q     <= '0;
						acc_q   <= TRIES_W'(1);
						state_q <= ST_WALK;
					end else begin
						idx_q <= idx_q + POS_W'(1);
					end
				end
				ST_WALK: begin
					if (!walk_bit && s_q != '0) begin
						acc_q <= acc_q + v_q;
					end
					if (last_pos) begin
						state_q <= ST_DONE;
					end else begin
						pat_q <= {1'b0, pat_q[MASK_W-1:1]};
						idx_q <= idx_q + POS_W'(1);
						if (walk_bit) begin
							s_q <= s_q + CNT_W'(1);
						end
						if (s_q != '0) begin
							state_q <= ST_WAIT;
						end else if (walk_bit) begin
							v_q <= TRIES_W'(1);
						end
					end
				end
				ST_WAIT: begin
					if (md_rsp.done) begin
						v_q     <= md_rsp.quot;
						state_q <= ST_WALK;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign done         = (state_q == ST_DONE);
	assign tries        = acc_q;
	assign found        = found_q & ~err_q;
	assign config_error = err_q;

	`CCSC_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`CCSC_ASSERT_NEXT(a_done_frees, clk, arst_n, done, !busy)
	`CCSC_ASSERT_IMPLY(a_err_zero, clk, arst_n, done && config_error, tries == '0 && !found)
	`CCSC_ASSERT_IMPLY(a_ok_nonzero, clk, arst_n, done && !config_error, tries != '0)

endmodule

>>> hw/rtl/ccsc_muldiv.sv
// ----------------------------------------------------------------------------
// ccsc_muldiv
// Computes value * mult / divisor for an exact quotient: one registered
// narrow multiply, then a bit-serial restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
module ccsc_muldiv import ccsc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  md_req_t req,
	output md_rsp_t rsp
);

	localparam int ITER_W = $clog2(PROD_W + 1);
	localparam int REM_W  = CNT_W - 1;

	logic              run_q;
	logic              done_q;
	logic [ITER_W-1:0] cnt_q;
	logic [PROD_W-1:0] dvd_q;
	logic [REM_W-1:0]  rem_q;
	logic [CNT_W-1:0]  d_q;

	logic [PROD_W-1:0] prod;
	logic [CNT_W-1:0]  trial;
	logic              qbit;

	assign prod  = PROD_W'(req.value) * PROD_W'(req.mult);
	assign trial = {rem_q, dvd_q[PROD_W-1]};
	assign qbit  = (trial >= d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= ITER_W'(PROD_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - ITER_W'(1);
			if (cnt_q == ITER_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= prod;
			rem_q <= '0;
			d_q   <= req.divisor;
		end else if (run_q) begin
			dvd_q <= {dvd_q[PROD_W-2:0], qbit};
			rem_q <= qbit ? REM_W'(trial - d_q) : REM_W'(trial);
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dvd_q[TRIES_W-1:0];

endmodule

>>> sim/tb_combination_cover_search_counter.sv
// ----------------------------------------------------------------------------
// tb_combination_cover_search_counter
// Feeds erasure masks under many data/check count settings, including bad
// lengths and extreme pattern sizes, and checks every result beat against a
// directed value or a Pascal's triangle rank of the first covering pattern.
// ----------------------------------------------------------------------------
module tb_combination_cover_search_counter;
	import ccsc_pkg::*;

	localparam int     LEN_LIMIT     = MAX_LEN_DEF;
	localparam int     RANDOM_SETS   = 32;
	localparam int     SETTLE_CYCLES = 16;
	localparam longint CYCLE_LIMIT   = 20_000_000;
	localparam longint C64_32        = 64'd1832624140942590534;
	localparam longint C31_5         = 64'd169911;

	typedef struct packed {
		logic [TRIES_W-1:0] tries;
		logic               found;
		logic               config_error;
	} cover_result_t;

	typedef struct packed {
		logic [CNT_W-1:0]  data_count;
		logic [CNT_W-1:0]  check_count;
		logic [MASK_W-1:0] mask;
		logic              typed;
		cover_result_t     want;
	} directed_row_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 start        = 1'b0;
	logic [MASK_W-1:0]    erasure_mask = '0;
	logic                 cfg_valid    = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index    = REG_DATA_COUNT;
	logic [CNT_W-1:0]     cfg_data     = '0;
	logic                 busy;
	logic                 cfg_ready;
	logic                 done;
	logic [TRIES_W-1:0]   tries;
	logic                 found;
	logic                 config_error;

	logic [CNT_W-1:0] data_count_q  = DATA_COUNT_RST;
	logic [CNT_W-1:0] check_count_q = CHECK_COUNT_RST;
	longint unsigned  pascal [0:64][0:64];
	cover_result_t    pending_counts [$];
	directed_row_t    directed_rows [$];
	int               mismatch_count = 0;
	longint           cycle_count    = 0;

	combination_cover_search_counter #(
		.MAX_LEN(LEN_LIMIT)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.erasure_mask(erasure_mask),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.done        (done),
		.tries       (tries),
		.found       (found),
		.config_error(config_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic cover_result_t rank_cover(input logic [MASK_W-1:0] mask);
		cover_result_t     res;
		logic [MASK_W-1:0] window;
		logic [MASK_W-1:0] pat;
		longint unsigned   count;
		int                n;
		int                r;
		int                ones;
		int                seen;
		int                need;
		res = '0;
		n = data_count_q + check_count_q;
		r = check_count_q;
		if (n == 0 || n > LEN_LIMIT) begin
			res.config_error = 1'b1;
			return res;
		end
		window = ~({MASK_W{1'b1}} >> n);
		pat = mask & window;
		ones = $countones(pat);
		if (ones > r) begin
			count = pascal[n][r];
		end else begin
			res.found = 1'b1;
			// fill the earliest free positions
			need = r - ones;
			for (int i = 0; i < n && need > 0; i++) begin
				if (!pat[MASK_W-1-i]) begin
					pat[MASK_W-1-i] = 1'b1;
					need--;
				end
			end
			count = 1;
			seen = 0;
			for (int i = 0; i < n; i++) begin
				if (pat[MASK_W-1-i]) begin
					seen++;
				end else begin
					need = r - seen - 1;
					if (need >= 0 && need <= n - i - 1)
						count += pascal[n-i-1][need];
				end
			end
		end
		res.tries = count[TRIES_W-1:0];
		return res;
	endfunction

	// k erasures in the length, random bits beyond; bad length or 15% all random
	function automatic logic [MASK_W-1:0] make_mask();
		logic [MASK_W-1:0] window;
		logic [MASK_W-1:0] m;
		int                n;
		int                r;
		int                k;
		int                sel;
		n = data_count_q + check_count_q;
		r = check_count_q;
		m = {$urandom, $urandom};
		sel = $urandom_range(99);
		if (n == 0 || n > LEN_LIMIT || sel < 15)
			return m;
		window = ~({MASK_W{1'b1}} >> n);
		m &= ~window;
		if (sel < 85 || r == n)
			k = $urandom_range(r);
		else
			k = $urandom_range(n, r + 1);
		while ($countones(m & window) < k)
			m[MASK_W - 1 - $urandom_range(n - 1)] = 1'b1;
		return m;
	endfunction

	task automatic add_row(input int dc, input int cc,
			input logic [MASK_W-1:0] mask, input logic typed,
			input longint unsigned want_tries, input logic want_found,
			input logic want_error);
		directed_row_t row;
		row.data_count        = CNT_W'(dc);
		row.check_count       = CNT_W'(cc);
		row.mask              = mask;
		row.typed             = typed;
		row.want.tries        = want_tries[TRIES_W-1:0];
		row.want.found        = want_found;
		row.want.config_error = want_error;
		directed_rows = {directed_rows, row};
	endtask

	task automatic send_mask(input logic [MASK_W-1:0] mask, input logic typed,
			input cover_result_t want, input int idle_pct);
		cover_result_t exp_res;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while (busy || $urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		erasure_mask <= mask;
		do @(posedge clk); while (busy);
		exp_res = typed ? want : rank_cover(mask);
		pending_counts = {pending_counts, exp_res};
	endtask

	task automatic settle();
		start <= 1'b0;
		while (pending_counts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [CNT_W-1:0] dc, input logic [CNT_W-1:0] cc);
		cfg_valid <= 1'b1;
		cfg_index <= REG_DATA_COUNT;
		cfg_data  <= dc;
		do @(posedge clk); while (!cfg_ready);
		data_count_q = dc;
		cfg_index <= REG_CHECK_COUNT;
		cfg_data  <= cc;
		do @(posedge clk); while (!cfg_ready);
		check_count_q = cc;
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		cover_result_t want;
		if (arst_n && done) begin
			if (pending_counts.size() == 0) begin
				$display("%0t unexpected beat: tries %0d found %0d config_error %0d",
					$time, tries, found, config_error);
				mismatch_count++;
			end else begin
				want = pending_counts.pop_front();
				if (tries !== want.tries) begin
					$display("%0t tries: expected %0d actual %0d", $time, want.tries, tries);
					mismatch_count++;
				end
				if (found !== want.found) begin
					$display("%0t found: expected %0d actual %0d", $time, want.found, found);
					mismatch_count++;
				end
				if (config_error !== want.config_error) begin
					$display("%0t config_error: expected %0d actual %0d",
						$time, want.config_error, config_error);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int n;
		int dc;
		int cc;
		int pick;
		int batch;
		int idle_pct;
		for (int a = 0; a <= 64; a++) begin
			for (int b = 0; b <= 64; b++)
				pascal[a][b] = 0;
			pascal[a][0] = 1;
			for (int b = 1; b <= a; b++)
				pascal[a][b] = pascal[a-1][b-1] + pascal[a-1][b];
		end

		// reset settings first, then bad lengths and the extremes
		add_row(26, 5, 64'h0, 1'b1, 1, 1'b1, 1'b0);
		add_row(26, 5, '1, 1'b1, C31_5, 1'b0, 1'b0);
		add_row(26, 5, 64'h8000_0000_0000_0000, 1'b1, 1, 1'b1, 1'b0);
		add_row(26, 5, 64'h0000_0002_0000_0000, 1'b0, 0, 1'b0, 1'b0);
		add_row(26, 5, 64'h0000_003E_0000_0000, 1'b1, C31_5, 1'b1, 1'b0);
		add_row(26, 5, 64'h0000_0001_FFFF_FFFF, 1'b1, 1, 1'b1, 1'b0);
		add_row(0, 0, 64'hA5A5_5A5A_C3C3_3C3C, 1'b1, 0, 1'b0, 1'b1);
		add_row(64, 1, 64'h1, 1'b1, 0, 1'b0, 1'b1);
		add_row(127, 127, '1, 1'b1, 0, 1'b0, 1'b1);
		add_row(60, 4, 64'h0F00_0000_0000_00F0, 1'b0, 0, 1'b0, 1'b0);
		add_row(61, 4, 64'h0, 1'b1, 0, 1'b0, 1'b1);
		add_row(0, 64, '1, 1'b1, 1, 1'b1, 1'b0);
		add_row(64, 0, 64'h0, 1'b1, 1, 1'b1, 1'b0);
		add_row(64, 0, 64'h8000_0000_0000_0000, 1'b1, 1, 1'b0, 1'b0);
		add_row(32, 32, 64'h0, 1'b1, 1, 1'b1, 1'b0);
		add_row(32, 32, 64'h0000_0000_FFFF_FFFF, 1'b1, C64_32, 1'b1, 1'b0);
		add_row(32, 32, '1, 1'b1, C64_32, 1'b0, 1'b0);
		add_row(32, 32, 64'h5555_5555_5555_5555, 1'b0, 0, 1'b0, 1'b0);
		add_row(1, 0, 64'h8000_0000_0000_0000, 1'b1, 1, 1'b0, 1'b0);
		add_row(0, 1, 64'h8000_0000_0000_0000, 1'b1, 1, 1'b1, 1'b0);
		add_row(63, 1, 64'h1, 1'b1, 64, 1'b1, 1'b0);
		add_row(1, 63, 64'h0, 1'b1, 1, 1'b1, 1'b0);
		add_row(1, 63, 64'h1, 1'b0, 0, 1'b0, 1'b0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].data_count != data_count_q ||
					directed_rows[i].check_count != check_count_q) begin
				settle();
				set_config(directed_rows[i].data_count, directed_rows[i].check_count);
			end
			send_mask(directed_rows[i].mask, directed_rows[i].typed,
				directed_rows[i].want, 0);
		end

		for (int s = 0; s < RANDOM_SETS; s++) begin
			idle_pct = (s % 4 == 1) ? 67 : (s % 4 == 3) ? 18 : 0;
			pick = $urandom_range(99);
			batch = 25;
			if (pick < 10) begin
				dc = $urandom_range(127);
				cc = $urandom_range(127, (dc > 64) ? 0 : 65 - dc);
				if (pick < 3) begin
					dc = 0;
					cc = 0;
				end
			end else if (pick < 20) begin
				// long patterns are slow, keep these sets short
				n = $urandom_range(64, 33);
				cc = $urandom_range(n);
				dc = n - cc;
				batch = 3;
			end else begin
				n = $urandom_range(14, 1);
				cc = $urandom_range(n);
				dc = n - cc;
			end
			settle();
			set_config(CNT_W'(dc), CNT_W'(cc));
			repeat (batch) send_mask(make_mask(), 1'b0, '0, idle_pct);
		end

		settle();
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/ccsc_pkg.sv
hw/rtl/ccsc_muldiv.sv
hw/rtl/combination_cover_search_counter.sv
sim/tb_combination_cover_search_counter.sv
